@@ hdl/pqt_pkg.sv @@
// Shared types and constants for the process page quota table.
// Request and result payloads, table entry layouts and the write bundle.
// No dependencies.
package pqt_pkg;

    localparam int ID_W         = 6;
    localparam int AMT_W        = 21;
    localparam int PAGE_W       = 20;
    localparam int CID_W        = 7;
    localparam int PAR_W        = 6;
    localparam int CC_W         = 2;
    localparam int KIND_W       = 3;

    localparam int ENTRY_COUNT  = 64;
    localparam int CHILD_LIMIT  = 3;
    localparam int ADDR_W       = $clog2(ENTRY_COUNT);
    localparam int CNT_W        = $clog2(CHILD_LIMIT + 1);
    localparam int CHILD_W      = ID_W + CNT_W + 1;

    localparam logic [AMT_W-1:0] USAGE_MAX = {AMT_W{1'b1}};

    typedef enum logic [KIND_W-1:0] {
        KIND_INIT_ROOT = 3'd0,
        KIND_CHECK     = 3'd1,
        KIND_SPLIT     = 3'd2,
        KIND_CHARGE    = 3'd3,
        KIND_RELEASE   = 3'd4
    } kind_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   id;
        logic [AMT_W-1:0]  amount;
        logic [PAGE_W-1:0] page_granted;
    } request_t;

    typedef struct packed {
        logic              ok;
        logic [CID_W-1:0]  child_id;
        logic [PAR_W-1:0]  parent_id;
        logic [CC_W-1:0]   child_count;
        logic [AMT_W-1:0]  quota_out;
        logic [AMT_W-1:0]  usage_out;
        logic [PAGE_W-1:0] page_out;
    } result_t;

    // written once when an entry is created
    typedef struct packed {
        logic [AMT_W-1:0]  quota;
        logic [PAR_W-1:0]  parent;
    } qp_entry_t;

    // written whenever the addressed entry changes
    typedef struct packed {
        logic [AMT_W-1:0]  usage;
        logic [CNT_W-1:0]  count;
    } uc_entry_t;

    typedef struct packed {
        logic              qp_we;
        logic [ADDR_W-1:0] qp_addr;
        qp_entry_t         qp_data;
        logic              uc_we;
        logic [ADDR_W-1:0] uc_addr;
        uc_entry_t         uc_data;
    } table_wr_t;

endpackage

@@ hdl/pqt_table.sv @@
// Entry storage: quota/parent and usage/count memories with registered reads,
// a fresh bit per entry (usage and count read as zero), and write bypass.
// Depends on pqt_pkg.
module pqt_table (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        rd_en,
    input  logic [pqt_pkg::ADDR_W-1:0]  rd_addr,
    input  pqt_pkg::table_wr_t          wr,
    output pqt_pkg::qp_entry_t          qp_entry,
    output pqt_pkg::uc_entry_t          uc_entry
);
    import pqt_pkg::*;

    qp_entry_t qp_mem [ENTRY_COUNT];
    uc_entry_t uc_mem [ENTRY_COUNT];

    qp_entry_t qp_rd_reg;
    uc_entry_t uc_rd_reg;
    qp_entry_t qp_fwd_reg;
    uc_entry_t uc_fwd_reg;
    logic      qp_hit_reg;
    logic      uc_hit_reg;
    logic      qp_hit_next;
    logic      uc_hit_next;
    logic [ADDR_W-1:0]      addr_reg;
    logic [ENTRY_COUNT-1:0] fresh_reg;
    logic [ENTRY_COUNT-1:0] fresh_next;

    always_ff @(posedge clk)
    begin
        if (wr.qp_we)
        begin
            qp_mem[wr.qp_addr] <= wr.qp_data;
        end
        if (wr.uc_we)
        begin
            uc_mem[wr.uc_addr] <= wr.uc_data;
        end
        if (rd_en)
        begin
            qp_rd_reg  <= qp_mem[rd_addr];
            uc_rd_reg  <= uc_mem[rd_addr];
            qp_fwd_reg <= wr.qp_data;
            uc_fwd_reg <= wr.uc_data;
        end
    end

    // a write landing on the same edge as the read is missed by the memory read, so it is forwarded instead
    assign qp_hit_next = wr.qp_we && (wr.qp_addr == rd_addr);
    assign uc_hit_next = wr.uc_we && (wr.uc_addr == rd_addr);

    always_comb
    begin
        fresh_next = fresh_reg;
        if (wr.uc_we)
        begin
            fresh_next[wr.uc_addr] = 1'b0;
        end
        if (wr.qp_we)
        begin
            fresh_next[wr.qp_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qp_hit_reg <= 1'b0;
            uc_hit_reg <= 1'b0;
            addr_reg   <= '0;
            fresh_reg  <= '0;
        end
        else
        begin
            fresh_reg <= fresh_next;
            if (rd_en)
            begin
                qp_hit_reg <= qp_hit_next;
                uc_hit_reg <= uc_hit_next;
                addr_reg   <= rd_addr;
            end
        end
    end

    always_comb
    begin
        qp_entry = qp_hit_reg ? qp_fwd_reg : qp_rd_reg;
        if (fresh_reg[addr_reg])
        begin
            uc_entry = '0;
        end
        else
        begin
            uc_entry = uc_hit_reg ? uc_fwd_reg : uc_rd_reg;
        end
    end

endmodule

@@ hdl/pqt_alu.sv @@
// Per-request update logic: headroom check, split, charge and release,
// producing the table write bundle and the result. Depends on pqt_pkg.
module pqt_alu (
    input  pqt_pkg::request_t   req,
    input  pqt_pkg::qp_entry_t  qp_entry,
    input  pqt_pkg::uc_entry_t  uc_entry,
    output pqt_pkg::table_wr_t  wr,
    output pqt_pkg::result_t    res
);
    import pqt_pkg::*;

    logic [AMT_W-1:0]   quota;
    logic [AMT_W-1:0]   usage;
    logic [CNT_W-1:0]   count;
    logic [AMT_W-1:0]   headroom;
    logic [AMT_W:0]     sum_amt;
    logic [AMT_W-1:0]   usage_plus_amt;
    logic [AMT_W-1:0]   usage_plus_one;
    logic [AMT_W-1:0]   usage_minus_one;
    logic [CHILD_W-1:0] child;
    logic               split_ok;

    always_comb
    begin
        quota = qp_entry.quota;
        usage = uc_entry.usage;
        count = uc_entry.count;

        headroom        = (quota >= usage) ? (quota - usage) : '0;
        sum_amt         = {1'b0, usage} + {1'b0, req.amount};
        usage_plus_amt  = sum_amt[AMT_W] ? USAGE_MAX : sum_amt[AMT_W-1:0];
        usage_plus_one  = (usage == USAGE_MAX) ? usage : usage + AMT_W'(1);
        usage_minus_one = (usage != '0) ? usage - AMT_W'(1) : usage;

        child = CHILD_W'(req.id) * CHILD_W'(CHILD_LIMIT) + CHILD_W'(1)
              + CHILD_W'(count);
        split_ok = (count < CNT_W'(CHILD_LIMIT)) && (child < CHILD_W'(ENTRY_COUNT));

        wr = '0;
        res.ok          = 1'b0;
        res.child_id    = CID_W'(ENTRY_COUNT);
        res.parent_id   = qp_entry.parent;
        res.child_count = CC_W'(count);
        res.quota_out   = quota;
        res.usage_out   = usage;
        res.page_out    = '0;

        case (req.kind)
            KIND_INIT_ROOT:
            begin
                wr.qp_we          = 1'b1;
                wr.qp_addr        = '0;
                wr.qp_data.quota  = req.amount;
                wr.qp_data.parent = '0;
                res.ok            = 1'b1;
                res.parent_id     = '0;
                res.child_count   = '0;
                res.quota_out     = req.amount;
                res.usage_out     = '0;
            end
            KIND_CHECK:
            begin
                res.ok = (headroom >= req.amount);
            end
            KIND_SPLIT:
            begin
                if (split_ok)
                begin
                    wr.uc_we          = 1'b1;
                    wr.uc_addr        = ADDR_W'(req.id);
                    wr.uc_data.usage  = usage_plus_amt;
                    wr.uc_data.count  = count + CNT_W'(1);
                    wr.qp_we          = 1'b1;
                    wr.qp_addr        = child[ADDR_W-1:0];
                    wr.qp_data.quota  = req.amount;
                    wr.qp_data.parent = PAR_W'(req.id);
                    res.ok            = 1'b1;
                    res.child_id      = CID_W'(child);
                    res.child_count   = CC_W'(count + CNT_W'(1));
                    res.usage_out     = usage_plus_amt;
                end
            end
            KIND_CHARGE:
            begin
                if (req.page_granted != '0)
                begin
                    wr.uc_we         = 1'b1;
                    wr.uc_addr       = ADDR_W'(req.id);
                    wr.uc_data.usage = usage_plus_one;
                    wr.uc_data.count = count;
                    res.ok           = 1'b1;
                    res.usage_out    = usage_plus_one;
                    res.page_out     = req.page_granted;
                end
            end
            KIND_RELEASE:
            begin
                wr.uc_we         = 1'b1;
                wr.uc_addr       = ADDR_W'(req.id);
                wr.uc_data.usage = usage_minus_one;
                wr.uc_data.count = count;
                res.usage_out    = usage_minus_one;
            end
            default:
            begin
                wr = '0;
            end
        endcase
    end

endmodule

@@ hdl/process_page_quota_table_unit.sv @@
// Top level of the process page quota table: request register, update logic,
// entry table and result register. Depends on pqt_pkg, pqt_table, pqt_alu.
//
// Takes one request per clock cycle while results are taken (res_ready) and
// returns one result for each; the result is loaded into the result register
// once that register is free or being taken, and is held there until taken. The entry memories
// are read when a request is accepted and written when its result is loaded
// into the result register; the result register lets one more request enter
// while a result waits, after which req_ready stays low until the result is
// taken. No clearing pass is needed after reset.
module process_page_quota_table_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  pqt_pkg::request_t req_data,
    output logic              res_valid,
    input  logic              res_ready,
    output pqt_pkg::result_t  res_data
);
    import pqt_pkg::*;

    logic      s1_valid_reg;
    request_t  s1_req_reg;
    logic      res_valid_reg;
    result_t   res_data_reg;

    logic      accept;
    logic      advance;
    logic      commit;
    logic [ADDR_W-1:0] rd_addr;
    qp_entry_t qp_entry;
    uc_entry_t uc_entry;
    table_wr_t alu_wr;
    table_wr_t tbl_wr;
    result_t   alu_res;

    assign advance   = !res_valid_reg || res_ready;
    assign req_ready = !s1_valid_reg || advance;
    assign accept    = req_valid && req_ready;
    assign commit    = s1_valid_reg && advance;
    assign rd_addr   = (req_data.kind == KIND_INIT_ROOT) ? '0 : ADDR_W'(req_data.id);

    always_comb
    begin
        tbl_wr       = alu_wr;
        tbl_wr.qp_we = alu_wr.qp_we && commit;
        tbl_wr.uc_we = alu_wr.uc_we && commit;
    end

    pqt_table u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept),
        .rd_addr  (rd_addr),
        .wr       (tbl_wr),
        .qp_entry (qp_entry),
        .uc_entry (uc_entry)
    );

    pqt_alu u_alu (
        .req      (s1_req_reg),
        .qp_entry (qp_entry),
        .uc_entry (uc_entry),
        .wr       (alu_wr),
        .res      (alu_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_ready)
            begin
                s1_valid_reg <= req_valid;
            end
            if (advance)
            begin
                res_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_req_reg <= req_data;
        end
        if (commit)
        begin
            res_data_reg <= alu_res;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

endmodule

@@ verif/pqt_quota_checker.sv @@
// Checker for the process page quota table: watches the request and result
// channels, keeps its own copy of the entry table and compares every result.
// Depends on pqt_pkg.
module pqt_quota_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic              req_ready,
    input  pqt_pkg::request_t req_data,
    input  logic              res_valid,
    input  logic              res_ready,
    input  pqt_pkg::result_t  res_data,
    output int                fail_count,
    output int                pending
);
    import pqt_pkg::*;

    logic [AMT_W-1:0] quota_tbl  [ENTRY_COUNT];
    logic [AMT_W-1:0] usage_tbl  [ENTRY_COUNT];
    logic [PAR_W-1:0] parent_tbl [ENTRY_COUNT];
    logic [CNT_W-1:0] kids_tbl   [ENTRY_COUNT];

    result_t expected_results[$];
    int      errors;
    int      results_seen;

    initial
    begin
        for (int i = 0; i < ENTRY_COUNT; i++)
        begin
            quota_tbl[i]  = '0;
            usage_tbl[i]  = '0;
            parent_tbl[i] = '0;
            kids_tbl[i]   = '0;
        end
        errors       = 0;
        results_seen = 0;
    end

    task automatic report_mismatch(string msg);
        $display("[%0t] quota table mismatch: %s", $time, msg);
        errors++;
    endtask

    function automatic result_t predict_quota_result(request_t r);
        result_t          res;
        logic [ID_W-1:0]  addr;
        logic [AMT_W-1:0] headroom;
        logic [AMT_W:0]   sum;
        int unsigned      nc;
        int unsigned      child;
        res          = '0;
        res.child_id = CID_W'(ENTRY_COUNT);
        addr         = r.id;
        case (r.kind)
            KIND_INIT_ROOT:
            begin
                addr          = '0;
                quota_tbl[0]  = r.amount;
                usage_tbl[0]  = '0;
                parent_tbl[0] = '0;
                kids_tbl[0]   = '0;
                res.ok        = 1'b1;
            end
            KIND_CHECK:
            begin
                headroom = (quota_tbl[r.id] >= usage_tbl[r.id]) ?
                           quota_tbl[r.id] - usage_tbl[r.id] : '0;
                res.ok   = (headroom >= r.amount);
            end
            KIND_SPLIT:
            begin
                nc    = kids_tbl[r.id];
                child = r.id * CHILD_LIMIT + 1 + nc;
                if (nc < CHILD_LIMIT && child < ENTRY_COUNT)
                begin
                    kids_tbl[r.id]    = kids_tbl[r.id] + 1'b1;
                    sum               = {1'b0, usage_tbl[r.id]} + {1'b0, r.amount};
                    usage_tbl[r.id]   = sum[AMT_W] ? USAGE_MAX : sum[AMT_W-1:0];
                    quota_tbl[child[ADDR_W-1:0]]  = r.amount;
                    usage_tbl[child[ADDR_W-1:0]]  = '0;
                    parent_tbl[child[ADDR_W-1:0]] = r.id;
                    kids_tbl[child[ADDR_W-1:0]]   = '0;
                    res.ok            = 1'b1;
                    res.child_id      = CID_W'(child);
                end
            end
            KIND_CHARGE:
            begin
                if (r.page_granted != '0)
                begin
                    if (usage_tbl[r.id] != USAGE_MAX)
                        usage_tbl[r.id] = usage_tbl[r.id] + 1'b1;
                    res.ok       = 1'b1;
                    res.page_out = r.page_granted;
                end
            end
            KIND_RELEASE:
            begin
                if (usage_tbl[r.id] != '0)
                    usage_tbl[r.id] = usage_tbl[r.id] - 1'b1;
            end
            default:
            begin
            end
        endcase
        res.parent_id   = parent_tbl[addr];
        res.child_count = kids_tbl[addr][CC_W-1:0];
        res.quota_out   = quota_tbl[addr];
        res.usage_out   = usage_tbl[addr];
        return res;
    endfunction

    task automatic compare_result(result_t got, result_t want);
        if (got.ok !== want.ok)
            report_mismatch($sformatf("result %0d ok got %0h expected %0h",
                            results_seen, got.ok, want.ok));
        if (got.child_id !== want.child_id)
            report_mismatch($sformatf("result %0d child_id got %0h expected %0h",
                            results_seen, got.child_id, want.child_id));
        if (got.parent_id !== want.parent_id)
            report_mismatch($sformatf("result %0d parent_id got %0h expected %0h",
                            results_seen, got.parent_id, want.parent_id));
        if (got.child_count !== want.child_count)
            report_mismatch($sformatf("result %0d child_count got %0h expected %0h",
                            results_seen, got.child_count, want.child_count));
        if (got.quota_out !== want.quota_out)
            report_mismatch($sformatf("result %0d quota_out got %0h expected %0h",
                            results_seen, got.quota_out, want.quota_out));
        if (got.usage_out !== want.usage_out)
            report_mismatch($sformatf("result %0d usage_out got %0h expected %0h",
                            results_seen, got.usage_out, want.usage_out));
        if (got.page_out !== want.page_out)
            report_mismatch($sformatf("result %0d page_out got %0h expected %0h",
                            results_seen, got.page_out, want.page_out));
    endtask

    // results first, so a stray result never pairs with a same-edge request
    always @(posedge clk)
    begin : watch_channels
        result_t want;
        if (rst_n)
        begin
            if (res_valid && res_ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch($sformatf("result %0d with no request outstanding",
                                    results_seen));
                else
                begin
                    want = expected_results.pop_front();
                    compare_result(res_data, want);
                end
                results_seen++;
            end
            if (req_valid && req_ready)
                expected_results.push_back(predict_quota_result(req_data));
        end
        pending    <= expected_results.size();
        fail_count <= errors;
    end

endmodule

@@ verif/process_page_quota_table_unit_tb.sv @@
// Testbench top for process_page_quota_table_unit: clock, reset, request and
// result traffic with random stalls, and the final verdict.
// Depends on pqt_pkg, pqt_quota_checker and the block itself.
module process_page_quota_table_unit_tb;
    import pqt_pkg::*;

    localparam int RANDOM_ITEMS = 1880;
    localparam int HOLD_AT      = 400;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_AT     = 1000;
    localparam int CALM_AT      = 1750;
    localparam int STALL_LIMIT  = 5000;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_ready;
    request_t req_data  = '0;
    logic     res_valid;
    logic     res_ready = 1'b0;
    result_t  res_data;

    int fail_count;
    int pending;
    int items_sent    = 0;
    int stall_cycles  = 0;
    int send_idle_pct = 10;
    bit calm_tail     = 1'b0;
    bit sink_holding  = 1'b0;

    // which entries have been written, as far as the request stream goes
    bit written  [ENTRY_COUNT];
    int kids_gen [ENTRY_COUNT];
    int live_ids [$];

    always #5 clk = ~clk;

    process_page_quota_table_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    pqt_quota_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req_data   (req_data),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_data   (res_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    function automatic void mark_live(int e);
        if (!written[e])
        begin
            written[e] = 1'b1;
            live_ids.push_back(e);
        end
        kids_gen[e] = 0;
    endfunction

    function automatic void note_request(request_t r);
        int c;
        if (r.kind == KIND_INIT_ROOT)
            mark_live(0);
        else if (r.kind == KIND_SPLIT)
        begin
            c = r.id * CHILD_LIMIT + 1 + kids_gen[r.id];
            if (kids_gen[r.id] < CHILD_LIMIT && c < ENTRY_COUNT)
            begin
                kids_gen[r.id]++;
                mark_live(c);
            end
        end
    endfunction

    function automatic logic [AMT_W-1:0] pick_amount();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return AMT_W'($urandom_range(0, 16));
            4, 5:       return AMT_W'($urandom_range(0, 1 << 20));
            6:          return $urandom_range(0, 1) ? USAGE_MAX : AMT_W'(1 << 20);
            default:    return AMT_W'($urandom());
        endcase
    endfunction

    function automatic logic [PAGE_W-1:0] pick_page();
        case ($urandom_range(0, 7))
            0, 1:    return '0;
            2:       return '1;
            default: return PAGE_W'($urandom());
        endcase
    endfunction

    function automatic int pick_idle_pct();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 10;
            default: return 35;
        endcase
    endfunction

    function automatic request_t make_random_request();
        request_t r;
        int       sel;
        int       cand[$];
        sel            = $urandom_range(0, 99);
        r.amount       = pick_amount();
        r.page_granted = pick_page();
        if (sel < 4)
            r.kind = KIND_INIT_ROOT;
        else if (sel < 26)
            r.kind = KIND_CHECK;
        else if (sel < 50)
            r.kind = KIND_SPLIT;
        else if (sel < 72)
            r.kind = KIND_CHARGE;
        else if (sel < 94)
            r.kind = KIND_RELEASE;
        else
            r.kind = KIND_W'($urandom_range(KIND_RELEASE + 1, (1 << KIND_W) - 1));
        if (r.kind == KIND_INIT_ROOT)
            r.id = ID_W'($urandom_range(0, ENTRY_COUNT - 1));
        else
        begin
            // splits mostly go to entries that still have room for a child
            if (r.kind == KIND_SPLIT && $urandom_range(0, 9) < 7)
                foreach (live_ids[i])
                    if (kids_gen[live_ids[i]] < CHILD_LIMIT &&
                        live_ids[i] * CHILD_LIMIT + 1 + kids_gen[live_ids[i]] < ENTRY_COUNT)
                        cand.push_back(live_ids[i]);
            if (cand.size() == 0)
                cand = live_ids;
            r.id = ID_W'(cand[$urandom_range(0, cand.size() - 1)]);
        end
        return r;
    endfunction

    task automatic issue_request(request_t r);
        note_request(r);
        req_data  <= r;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        items_sent++;
    endtask

    task automatic send_fields(logic [KIND_W-1:0] k, int id, logic [AMT_W-1:0] amount,
                               logic [PAGE_W-1:0] page);
        request_t r;
        r.kind         = k;
        r.id           = ID_W'(id);
        r.amount       = amount;
        r.page_granted = page;
        issue_request(r);
    endtask

    task automatic sender_pause();
        int n;
        if (!calm_tail && !sink_holding && $urandom_range(0, 99) < send_idle_pct)
        begin
            n = $urandom_range(1, 11);
            req_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic wait_for_drain();
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        request_t r;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: root setup, headroom edges, usage bounds, split failures
        send_fields(KIND_INIT_ROOT, 37, 1000, '0);
        send_fields(KIND_CHECK, 0, 1000, '0);
        send_fields(KIND_CHECK, 0, 1001, '0);
        send_fields(KIND_RELEASE, 0, '0, '0);
        send_fields(KIND_CHARGE, 0, '0, '0);
        send_fields(KIND_CHARGE, 0, '0, '1);
        send_fields(KIND_SPLIT, 0, USAGE_MAX, '0);
        send_fields(KIND_CHECK, 0, '0, '0);
        send_fields(KIND_CHARGE, 0, '0, 1);
        send_fields(KIND_SPLIT, 0, '0, '0);
        send_fields(KIND_SPLIT, 0, AMT_W'(1 << 20), '0);
        send_fields(KIND_SPLIT, 0, 5, '0);
        send_fields(KIND_RELEASE, 1, '0, '0);
        for (int i = 0; i < CHILD_LIMIT; i++)
            send_fields(KIND_SPLIT, 1, AMT_W'(i), '0);
        for (int i = 0; i < CHILD_LIMIT; i++)
            send_fields(KIND_SPLIT, 6, 100, '0);
        send_fields(KIND_SPLIT, 21, 7, '0);
        send_fields(KIND_SPLIT, 20, 9, '0);
        for (int k = KIND_RELEASE + 1; k < (1 << KIND_W); k++)
            send_fields(KIND_W'(k), 0, USAGE_MAX, '1);
        send_fields(KIND_CHECK, 61, USAGE_MAX, '0);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 100 == 0)
                send_idle_pct = pick_idle_pct();
            if (i == CALM_AT)
                calm_tail = 1'b1;
            if (i == DRAIN_AT)
            begin
                req_valid <= 1'b0;
                wait_for_drain();
            end
            r = make_random_request();
            issue_request(r);
            sender_pause();
        end
        req_valid <= 1'b0;
        wait_for_drain();
        repeat (20) @(posedge clk);

        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : result_sink
        int  cycle;
        int  idle_pct;
        int  n;
        bit  hold_done;
        cycle     = 0;
        idle_pct  = 15;
        hold_done = 1'b0;
        wait (rst_n);
        forever
        begin
            cycle++;
            if (cycle % 200 == 0)
                idle_pct = pick_idle_pct();
            if (!hold_done && items_sent >= HOLD_AT)
            begin
                sink_holding = 1'b1;
                res_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                sink_holding = 1'b0;
                hold_done    = 1'b1;
            end
            else if (!calm_tail && $urandom_range(0, 99) < idle_pct)
            begin
                n = $urandom_range(1, 11);
                res_ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            res_ready <= 1'b1;
            @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (res_valid && res_ready))
                stall_cycles <= 0;
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

endmodule

@@ files.f @@
hdl/pqt_pkg.sv
hdl/pqt_table.sv
hdl/pqt_alu.sv
hdl/process_page_quota_table_unit.sv
verif/pqt_quota_checker.sv
verif/process_page_quota_table_unit_tb.sv
